// ----- rtl/core/lwp_pkg.sv -----
// Package for the LoRaWAN uplink frame parser: frame layout constants,
// result and status codes, and the result record passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package lwp_pkg;

  // Frame layout
  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int MIN_FRAME           = 12;
  localparam int MIC_BYTES           = 4;
  localparam logic [3:0] OPTS_MASK   = 4'hF;

  // Header byte positions
  localparam int POS_MHDR     = 0;
  localparam int POS_ADDR0    = 1;
  localparam int POS_ADDR3    = 4;
  localparam int POS_FCTRL    = 5;
  localparam int POS_FCNT0    = 6;
  localparam int POS_FCNT1    = 7;
  localparam int POS_PORT_MIN = 8;

  // Port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 112;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_OVERRUN = 2'd2
  } lwp_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } lwp_kind_t;

  typedef struct packed {
    lwp_kind_t   kind;
    logic [7:0]  payload_byte;
    logic [7:0]  header_byte;
    logic [31:0] device_address;
    logic [15:0] frame_counter;
    logic        port_present;
    logic [7:0]  port_number;
    logic [31:0] integrity_code;
    lwp_status_t status;
  } lwp_result_t;

endpackage

// ----- rtl/core/lwp_parse.sv -----
// Per-byte frame parser: position counter, captured header fields and the
// result record for one byte. Depends on lwp_pkg.
`timescale 1ns / 1ps

module lwp_parse import lwp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,          // consume the byte below this cycle
  input  logic [7:0]  data_byte,
  input  logic [8:0]  frame_length,
  output logic        res_valid,
  output lwp_result_t res
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW    = LEN_W + 2;  // room for 12 + options and port position

  // Frame state
  logic [LEN_W-1:0] byte_position, byte_position_next;
  logic [LEN_W-1:0] held_length,   held_length_next;
  logic [7:0]       held_header,   held_header_next;
  logic [31:0]      held_address,  held_address_next;
  logic [3:0]       options_count, options_count_next;
  logic [15:0]      held_counter,  held_counter_next;
  logic [7:0]       held_port,     held_port_next;
  logic [31:0]      held_integrity, held_integrity_next;

  logic             first;
  logic [LEN_W-1:0] len_sat;
  logic [1:0]       mic_diff;
  logic [CW-1:0]    pos_w, len_w, port_pos, min_opts;
  logic             mic_hit, body, port_hit, pay_hit, last_byte;

  // Length saturation for the first byte of a frame
  always_comb begin
    if (frame_length == 9'd0) begin
      len_sat = LEN_W'(1);
    end else if (frame_length > 9'(MAX_FRAME_BYTES)) begin
      len_sat = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      len_sat = LEN_W'(frame_length);
    end
  end

  // Field capture and result decode
  always_comb begin
    first = (byte_position == '0);

    // start from a clean slate on a frame's first byte
    held_length_next    = first ? len_sat : held_length;
    held_header_next    = first ? 8'd0  : held_header;
    held_address_next   = first ? 32'd0 : held_address;
    options_count_next  = first ? 4'd0  : options_count;
    held_counter_next   = first ? 16'd0 : held_counter;
    held_port_next      = first ? 8'd0  : held_port;
    held_integrity_next = first ? 32'd0 : held_integrity;

    pos_w = CW'(byte_position);
    len_w = CW'(held_length_next);

    case (byte_position)
      LEN_W'(POS_MHDR):  held_header_next = data_byte;
      LEN_W'(POS_ADDR0): held_address_next[7:0]   = data_byte;
      LEN_W'(2):         held_address_next[15:8]  = data_byte;
      LEN_W'(3):         held_address_next[23:16] = data_byte;
      LEN_W'(POS_ADDR3): held_address_next[31:24] = data_byte;
      LEN_W'(POS_FCTRL): options_count_next = data_byte[3:0] & OPTS_MASK;
      LEN_W'(POS_FCNT0): held_counter_next[7:0]  = data_byte;
      LEN_W'(POS_FCNT1): held_counter_next[15:8] = data_byte;
      default: ;
    endcase

    // MIC: the last four positions; byte index is (pos + 4 - len) mod 4
    mic_hit  = (pos_w + CW'(MIC_BYTES)) >= len_w;
    mic_diff = 2'(byte_position - held_length_next);
    if (mic_hit) begin
      case (mic_diff)
        2'd0:    held_integrity_next[7:0]   = data_byte;
        2'd1:    held_integrity_next[15:8]  = data_byte;
        2'd2:    held_integrity_next[23:16] = data_byte;
        default: held_integrity_next[31:24] = data_byte;
      endcase
    end

    // port and payload region
    port_pos = CW'(POS_PORT_MIN) + CW'(options_count_next);
    min_opts = CW'(MIN_FRAME) + CW'(options_count_next);
    body     = (len_w >= CW'(MIN_FRAME)) && !mic_hit;
    port_hit = body && (pos_w >= CW'(POS_PORT_MIN)) && (pos_w == port_pos);
    pay_hit  = body && (pos_w > port_pos) && (pos_w > CW'(POS_PORT_MIN));
    if (port_hit) begin
      held_port_next = data_byte;
    end

    last_byte = (pos_w + CW'(1)) >= len_w;

    // result record
    res = '0;
    res_valid = 1'b0;
    if (pay_hit) begin
      res_valid        = 1'b1;
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = data_byte;
    end else if (last_byte) begin
      res_valid          = 1'b1;
      res.kind           = KIND_SUMMARY;
      res.header_byte    = held_header_next;
      res.device_address = held_address_next;
      res.frame_counter  = held_counter_next;
      res.integrity_code = held_integrity_next;
      if (len_w < CW'(MIN_FRAME)) begin
        res.status = ST_SHORT;
      end else if (len_w < min_opts) begin
        res.status = ST_OVERRUN;
      end else begin
        res.status       = ST_OK;
        res.port_present = (len_w > min_opts);
        res.port_number  = (len_w > min_opts) ? held_port_next : 8'd0;
      end
    end

    byte_position_next = (last_byte && !pay_hit) ? '0 : byte_position + LEN_W'(1);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      held_length    <= '0;
      held_header    <= '0;
      held_address   <= '0;
      options_count  <= '0;
      held_counter   <= '0;
      held_port      <= '0;
      held_integrity <= '0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      held_length    <= held_length_next;
      held_header    <= held_header_next;
      held_address   <= held_address_next;
      options_count  <= options_count_next;
      held_counter   <= held_counter_next;
      held_port      <= held_port_next;
      held_integrity <= held_integrity_next;
    end
  end

endmodule

// ----- rtl/core/lorawan_uplink_frame_parser.sv -----
// LoRaWAN uplink frame parser, top level: input register, parser core and
// output register with the stream handshakes. Depends on lwp_pkg, lwp_parse.
`timescale 1ns / 1ps

// Accepts one frame byte per beat, one beat per cycle, with frame_length
// sampled on the first byte of each frame. Each byte passes the input register
// and then the result register on its way to a result beat; a new byte can
// enter every cycle as long as the output side keeps taking beats.
// Application payload bytes come out as kind-0 beats as they arrive; the
// frame's last byte yields one kind-1 summary beat with MHDR, DevAddr, FCnt,
// FPort, MIC and a status (ok, short frame, options overrun). Header and
// MIC bytes that are not the last produce no output beat.

module lorawan_uplink_frame_parser import lwp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte, [16:8] frame_length
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // payload_byte 8, header_byte 8,
                                           // device_address 32, frame_counter 16,
                                           // port_present 1, port_number 8,
                                           // integrity_code 32, status 2
  output logic                  m_tuser    // result_kind
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic [8:0]  in_len;
  logic        advance;
  logic        res_valid;
  lwp_result_t res;
  lwp_result_t out_res;
  logic        out_valid;

  // byte moves into the parser when the result register can take its output
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[7:0];
      in_len  <= s_tdata[16:8];
    end
  end

  lwp_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_byte    (in_byte),
    .frame_length (in_len),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  // Pack the result beat
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {5'd0, out_res.status, out_res.integrity_code, out_res.port_number,
                     out_res.port_present, out_res.frame_counter, out_res.device_address,
                     out_res.header_byte, out_res.payload_byte};

endmodule

// ----- rtl/core/lwp_checker.sv -----
// Port-level checks for the LoRaWAN uplink frame parser, bound to the top
// level. Depends on lwp_pkg.
`timescale 1ns / 1ps

module lwp_checker import lwp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // payload beats carry nothing but the payload byte
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_PAYLOAD) |-> (m_tdata[OUT_DATA_W-1:8] == '0))
    else $error("payload beat has summary fields set");

  // status code is one of the defined ones
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_SUMMARY) |-> (m_tdata[106:105] != 2'd3))
    else $error("undefined status code");

  // a bad frame never reports a port
  a_bad_no_port: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[106:105] != ST_OK) |-> !m_tdata[64])
    else $error("port reported on a bad frame");

  // an absent port reads as zero
  a_port_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[64] |-> (m_tdata[72:65] == 8'd0))
    else $error("port number set without port");

endmodule

bind lorawan_uplink_frame_parser lwp_checker u_lwp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/testbench.sv -----
// Self-checking bench for lorawan_uplink_frame_parser: directed frames, then random
// frames, with every result beat checked against an in-bench frame parser.
// Depends on lwp_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import lwp_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // one row of the directed table; typed rows carry their own expected summary
  typedef struct packed {
    logic [7:0]  data;
    logic [8:0]  flen;
    logic        typed;
    lwp_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;

  // parser state kept by the bench
  int          cur_pos = 0;
  int          cur_len = 0;
  logic [7:0]  cap_mhdr = '0;
  logic [31:0] cap_addr = '0;
  logic [3:0]  cap_opts = '0;
  logic [15:0] cap_fcnt = '0;
  logic [7:0]  cap_port = '0;
  logic [31:0] cap_mic = '0;

  lwp_result_t frame_results_due [$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  steady = 1'b0;

  always #1 clk = ~clk;

  lorawan_uplink_frame_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic lwp_result_t frame_summary(input logic [7:0] hdr, input logic [31:0] addr,
                                                input logic [15:0] fcnt, input logic port_on,
                                                input logic [7:0] port, input logic [31:0] mic,
                                                input lwp_status_t st);
    lwp_result_t r;
    r = '0;
    r.kind           = KIND_SUMMARY;
    r.header_byte    = hdr;
    r.device_address = addr;
    r.frame_counter  = fcnt;
    r.port_present   = port_on;
    r.port_number    = port;
    r.integrity_code = mic;
    r.status         = st;
    return r;
  endfunction

  // Advance the bench parser by one byte; returns 1 when the byte yields a beat
  function automatic bit parse_frame_byte(input logic [7:0] b, input logic [8:0] flen,
                                          output lwp_result_t res);
    int pos;
    int len;
    int port_pos;
    lwp_status_t st;
    bit port_on;
    res = '0;
    // first byte: latch length (zero means one, clamp at max) and clear captures
    if (cur_pos == 0) begin
      if (flen == 0) cur_len = 1;
      else if (flen > MAX_FRAME_BYTES_DEF) cur_len = MAX_FRAME_BYTES_DEF;
      else cur_len = int'(flen);
      cap_mhdr = '0;
      cap_addr = '0;
      cap_opts = '0;
      cap_fcnt = '0;
      cap_port = '0;
      cap_mic  = '0;
    end
    pos = cur_pos;
    len = cur_len;
    port_pos = POS_PORT_MIN + int'(cap_opts);

    // header capture by position
    if (pos == POS_MHDR) cap_mhdr = b;
    else if (pos <= POS_ADDR3) cap_addr |= 32'(b) << (8 * (pos - POS_ADDR0));
    else if (pos == POS_FCTRL) cap_opts = b[3:0] & OPTS_MASK;
    else if (pos == POS_FCNT0 || pos == POS_FCNT1)
      cap_fcnt |= 16'(b) << (8 * (pos - POS_FCNT0));

    // trailing bytes build the MIC
    if (pos + MIC_BYTES >= len) cap_mic |= 32'(b) << (8 * (pos + MIC_BYTES - len));

    // port, then payload, only in a well-sized frame
    if (len >= MIN_FRAME && pos + MIC_BYTES < len) begin
      if (pos >= POS_PORT_MIN && pos == port_pos) begin
        cap_port = b;
      end else if (pos > port_pos && pos > POS_PORT_MIN) begin
        res.kind = KIND_PAYLOAD;
        res.payload_byte = b;
        cur_pos = pos + 1;
        return 1'b1;
      end
    end

    // last byte: summary
    if (pos + 1 >= len) begin
      port_on = 1'b0;
      if (len < MIN_FRAME) st = ST_SHORT;
      else if (len < MIN_FRAME + int'(cap_opts)) st = ST_OVERRUN;
      else begin
        st = ST_OK;
        port_on = (len > MIN_FRAME + int'(cap_opts));
      end
      res = frame_summary(cap_mhdr, cap_addr, cap_fcnt, port_on,
                          port_on ? cap_port : 8'h00, cap_mic, st);
      cur_pos = 0;
      return 1'b1;
    end
    cur_pos = pos + 1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, field, got, want);
    mismatch_count++;
  endtask

  // Drive one byte beat after a random gap; log its expectation once taken
  task automatic send_byte(input logic [7:0] b, input logic [8:0] flen, input logic typed,
                           input lwp_result_t typed_res);
    int gap;
    lwp_result_t res;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, flen, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (parse_frame_byte(b, flen, res))
      frame_results_due.push_back(typed ? typed_res : res);
  endtask

  // Result side: random stalls, field-by-field check of each beat
  always @(posedge clk) begin : result_sink
    int pause;
    lwp_result_t got;
    lwp_result_t want;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      pause = stall_left;
      if (m_tvalid && m_tready) begin
        got.kind           = lwp_kind_t'(m_tuser);
        got.payload_byte   = m_tdata[7:0];
        got.header_byte    = m_tdata[15:8];
        got.device_address = m_tdata[47:16];
        got.frame_counter  = m_tdata[63:48];
        got.port_present   = m_tdata[64];
        got.port_number    = m_tdata[72:65];
        got.integrity_code = m_tdata[104:73];
        got.status         = lwp_status_t'(m_tdata[106:105]);
        if (frame_results_due.size() == 0) begin
          report_mismatch("beat with nothing pending", m_tdata[31:0], '0);
        end else begin
          want = frame_results_due.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("result_kind", 32'(got.kind), 32'(want.kind));
          if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
          if (got.header_byte !== want.header_byte)
            report_mismatch("header_byte", 32'(got.header_byte), 32'(want.header_byte));
          if (got.device_address !== want.device_address)
            report_mismatch("device_address", got.device_address, want.device_address);
          if (got.frame_counter !== want.frame_counter)
            report_mismatch("frame_counter", 32'(got.frame_counter), 32'(want.frame_counter));
          if (got.port_present !== want.port_present)
            report_mismatch("port_present", 32'(got.port_present), 32'(want.port_present));
          if (got.port_number !== want.port_number)
            report_mismatch("port_number", 32'(got.port_number), 32'(want.port_number));
          if (got.integrity_code !== want.integrity_code)
            report_mismatch("integrity_code", got.integrity_code, want.integrity_code);
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        pause = steady ? 0 : $urandom_range(0, 3);
      end
      if (pause > 0) begin
        m_tready   <= 1'b0;
        stall_left <= pause - 1;
      end else begin
        m_tready   <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    stim_row_t rows [25];
    lwp_result_t unused;
    logic [7:0] fctrl;
    int flen;
    int len;
    int opts;
    int pick;
    int sent;
    unused = '0;

    // zero length taken as a one-byte short frame; the lone byte lands in MIC bits 31:24
    rows[0]  = '{8'hFF, 9'd0, 1'b1,
                 frame_summary(8'hFF, 32'h0, 16'h0, 1'b0, 8'h00, 32'hFF00_0000, ST_SHORT)};
    // options overrun: 12 bytes with FOpts length 15
    rows[1]  = '{8'h40, 9'd12,  1'b0, '0};
    rows[2]  = '{8'h01, 9'h1FF, 1'b0, '0};
    rows[3]  = '{8'h02, 9'h1FF, 1'b0, '0};
    rows[4]  = '{8'h03, 9'h1FF, 1'b0, '0};
    rows[5]  = '{8'h04, 9'h1FF, 1'b0, '0};
    rows[6]  = '{8'h0F, 9'h1FF, 1'b0, '0};
    rows[7]  = '{8'h34, 9'h1FF, 1'b0, '0};
    rows[8]  = '{8'h12, 9'h1FF, 1'b0, '0};
    rows[9]  = '{8'hA0, 9'h1FF, 1'b0, '0};
    rows[10] = '{8'hA1, 9'h1FF, 1'b0, '0};
    rows[11] = '{8'hA2, 9'h1FF, 1'b0, '0};
    rows[12] = '{8'hA3, 9'h1FF, 1'b1,
                 frame_summary(8'h40, 32'h0403_0201, 16'h1234, 1'b0, 8'h00, 32'hA3A2_A1A0,
                               ST_OVERRUN)};
    // exact fit: 12 bytes, no options, so no port and no payload
    rows[13] = '{8'h00, 9'd12,  1'b0, '0};
    rows[14] = '{8'hEF, 9'h000, 1'b0, '0};
    rows[15] = '{8'hBE, 9'h000, 1'b0, '0};
    rows[16] = '{8'hAD, 9'h000, 1'b0, '0};
    rows[17] = '{8'hDE, 9'h000, 1'b0, '0};
    rows[18] = '{8'hF0, 9'h000, 1'b0, '0};
    rows[19] = '{8'hFF, 9'h000, 1'b0, '0};
    rows[20] = '{8'hFF, 9'h000, 1'b0, '0};
    rows[21] = '{8'h11, 9'h000, 1'b0, '0};
    rows[22] = '{8'h22, 9'h000, 1'b0, '0};
    rows[23] = '{8'h33, 9'h000, 1'b0, '0};
    rows[24] = '{8'h44, 9'h000, 1'b1,
                 frame_summary(8'h00, 32'hDEAD_BEEF, 16'hFFFF, 1'b0, 8'h00, 32'h4433_2211,
                               ST_OK)};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_byte(rows[i].data, rows[i].flen, rows[i].typed, rows[i].res);

    // random frames, mostly well formed with random content
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      fctrl = 8'($urandom);
      opts = int'(fctrl[3:0]);
      pick = $urandom_range(0, 99);
      if (pick < 55) flen = MIN_FRAME + opts + $urandom_range(2, 20);
      else if (pick < 65) flen = MIN_FRAME + opts + $urandom_range(0, 1);
      else if (pick < 77) flen = $urandom_range(1, MIN_FRAME - 1);
      else if (pick < 89) flen = (opts == 0) ? MIN_FRAME : MIN_FRAME + $urandom_range(0, opts - 1);
      else if (pick < 93) flen = 0;
      else if (pick < 96) flen = $urandom_range(200, MAX_FRAME_BYTES_DEF);
      else flen = $urandom_range(MAX_FRAME_BYTES_DEF + 1, 511);
      if (flen == 0) len = 1;
      else if (flen > MAX_FRAME_BYTES_DEF) len = MAX_FRAME_BYTES_DEF;
      else len = flen;
      for (int p = 0; p < len; p++)
        send_byte((p == POS_FCTRL) ? fctrl : 8'($urandom),
                  (p == 0) ? 9'(flen) : 9'($urandom_range(0, 511)), 1'b0, unused);
      sent += len;
    end
    s_tvalid <= 1'b0;

    // drain
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
